// ===== src/sef_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package sef_pkg;

  localparam int MaxLen = 1024;
  localparam int SampleW = 16;
  localparam int IdxW = 10;
  localparam int MagW = 16;
  localparam int CntW = $clog2(MaxLen + 1);
  localparam int PosW = (CntW > IdxW) ? CntW : IdxW;

  typedef struct packed {
    logic signed [SampleW-1:0] sample;
    logic                      last;
  } sef_in_t;

  typedef struct packed {
    logic [IdxW-1:0] edge_index;
    logic [MagW-1:0] edge_magnitude;
  } sef_out_t;

  typedef struct packed {
    logic     valid;
    sef_out_t data;
  } sef_result_t;

endpackage

`default_nettype wire

// ===== src/sef_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sef_core
  import sef_pkg::*;
(
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         beat_i,
  input  sef_in_t     in_data_i,
  output sef_result_t result_o
);

  logic signed [SampleW-1:0] older_q, older_d;
  logic signed [SampleW-1:0] newer_q, newer_d;
  logic [CntW-1:0]           count_q, count_d;
  logic [MagW-1:0]           best_mag_q, best_mag_d;
  logic [IdxW-1:0]           best_pos_q, best_pos_d;

  logic signed [SampleW:0]   diff;
  logic [SampleW:0]          mag;
  logic [PosW-1:0]           pos_full;
  logic                      active;
  logic                      interior;

  assign diff     = {in_data_i.sample[SampleW-1], in_data_i.sample} - {older_q[SampleW-1], older_q};
  assign mag      = diff[SampleW] ? (SampleW+1)'(-diff) : diff;
  assign pos_full = PosW'(count_q) - PosW'(1);
  assign active   = count_q < CntW'(MaxLen);
  assign interior = count_q >= CntW'(2);

  always_comb begin
    older_d    = older_q;
    newer_d    = newer_q;
    count_d    = count_q;
    best_mag_d = best_mag_q;
    best_pos_d = best_pos_q;
    if (beat_i && active) begin
      if (interior && (mag > {1'b0, best_mag_q})) begin
        best_mag_d = mag[MagW-1:0];
        best_pos_d = pos_full[IdxW-1:0];
      end
      older_d = newer_q;
      newer_d = in_data_i.sample;
      count_d = count_q + CntW'(1);
    end
  end

  assign result_o.valid               = beat_i && in_data_i.last;
  assign result_o.data.edge_index     = best_pos_d;
  assign result_o.data.edge_magnitude = best_mag_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      older_q    <= '0;
      newer_q    <= '0;
      count_q    <= '0;
      best_mag_q <= '0;
      best_pos_q <= '0;
    end else if (beat_i && in_data_i.last) begin
      older_q    <= '0;
      newer_q    <= '0;
      count_q    <= '0;
      best_mag_q <= '0;
      best_pos_q <= '0;
    end else begin
      older_q    <= older_d;
      newer_q    <= newer_d;
      count_q    <= count_d;
      best_mag_q <= best_mag_d;
      best_pos_q <= best_pos_d;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MaxLen))
    else $error("sample count past max length");

  a_zero_best: assert property (@(posedge clk_i) disable iff (!rst_ni)
    best_mag_q == '0 |-> best_pos_q == '0)
    else $error("position set without a response");

  a_clear_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    beat_i && in_data_i.last |=> count_q == '0 && best_mag_q == '0)
    else $error("state not cleared after last beat");

endmodule

`default_nettype wire

// ===== src/strongest_edge_finder.sv =====
`timescale 1ns / 1ps
`default_nettype none
// The result goes to the output register, or to the skid entry if the output is held.
// One sample per cycle unless stalled; window, compare, best update are combinational.
// Results pass a two-entry output buffer; input stalls only when both entries are full.
// Reset (rst_ni low, async): window, count, best response and output buffer clear.

module strongest_edge_finder
  import sef_pkg::*;
(
  input  wire      clk_i,
  input  wire      rst_ni,
  input  wire      in_valid_i,
  output logic     in_stall_o,
  input  sef_in_t  in_data_i,
  output logic     out_valid_o,
  input  wire      out_stall_i,
  output sef_out_t out_data_o
);

  sef_result_t result;
  logic        beat;
  logic        pop;

  logic        out_valid_q, out_valid_d;
  logic        skid_valid_q, skid_valid_d;
  sef_out_t    out_q, out_d;
  sef_out_t    skid_q, skid_d;

  assign in_stall_o = skid_valid_q;
  assign beat       = in_valid_i && !in_stall_o;
  assign pop        = out_valid_q && !out_stall_i;

  sef_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .beat_i    (beat),
    .in_data_i (in_data_i),
    .result_o  (result)
  );

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (!out_valid_q) begin
      out_valid_d = result.valid;
      out_d       = result.data;
    end else if (pop) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        skid_valid_d = result.valid;
        skid_d       = result.data;
      end else begin
        out_valid_d = result.valid;
        out_d       = result.data;
      end
    end else if (result.valid) begin
      skid_valid_d = 1'b1;
      skid_d       = result.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry held with empty output");

  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i && !skid_valid_q && result.valid |=> skid_valid_q)
    else $error("result lost while output stalled");

  a_empty_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.edge_magnitude == '0 |-> out_data_o.edge_index == '0)
    else $error("index given without a response");

endmodule

`default_nettype wire
